@@ rtl/echo_range_trimmed_average_macros.svh @@
// Assertion helpers for the echo ranging RTL; erta_back uses them.
// The modules that use them name their clock aclk and their reset aresetn.
`ifndef ECHO_RANGE_TRIMMED_AVERAGE_MACROS_SVH
`define ECHO_RANGE_TRIMMED_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define ERTA_ASSERT(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("erta assertion failed");
`define ERTA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("erta assertion failed");
`else
`define ERTA_ASSERT(name, cond)
`define ERTA_ASSERT_IMPLY(name, ante, cons)
`endif
`endif

@@ rtl/erta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package erta_pkg;

    localparam int unsigned TIME_W   = 18;
    localparam int unsigned DIST_W   = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SUM_W    = 18;
    localparam int unsigned GOOD_W   = 9;
    localparam int unsigned RETRY_W  = 3;
    localparam int unsigned RUN_W    = 8;

    // Distance by reciprocal: q = (t * CM_RECIP) >> RECIP_SHIFT is the
    // true quotient of t*100/5882 or one below it.
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned PROD_W      = TIME_W + RECIP_W;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int unsigned SCALED_W    = 26;
    localparam logic [RECIP_W-1:0]  CM_RECIP       = 27'd73018825;
    localparam logic [QUOT_W-1:0]   US_PER_CM_X100 = 13'd5882;
    localparam logic [6:0]          US_SCALE       = 7'd100;
    localparam logic [DIST_W-1:0]   LOWEST_RESET   = 10'd999;
    localparam logic [DIST_W-1:0]   DIST_SAT       = 10'h3FF;

    localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABORT  = 2'd2;

    localparam logic [0:0] REG_AVG_EN  = 1'b0;
    localparam logic [0:0] REG_RUN_LEN = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    typedef struct packed {
        logic             avg_en;
        logic [RUN_W-1:0] run_length;
    } erta_cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
    } erta_req_t;

endpackage
`default_nettype wire

@@ rtl/erta_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module erta_front #(
    parameter int unsigned MAX_DIST   = 400,
    parameter int unsigned TIMEOUT_US = 150000
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [erta_pkg::TIME_W-1:0]   echo_time_us,
    input  wire logic                          echo_stuck,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output erta_pkg::erta_req_t                push_data
);
    import erta_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_SCL  = 3'd2;
    localparam logic [2:0] F_FIX  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic                stuck_reg, stuck_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic [SCALED_W-1:0] qm_reg, qm_next;
    logic [DIST_W-1:0]   d_reg, d_next;

    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] t_scaled;
    logic [SCALED_W-1:0] rem;
    logic [QUOT_W-1:0]   dq;
    logic                fail;

    assign prod     = PROD_W'(t_reg) * PROD_W'(CM_RECIP);
    assign t_scaled = SCALED_W'(t_reg) * SCALED_W'(US_SCALE);
    assign rem      = t_scaled - qm_reg;
    assign dq       = q_reg + QUOT_W'(rem >= SCALED_W'(US_PER_CM_X100));
    // Stuck line, timeout, zero and out-of-range readings all read as the maximum.
    assign fail     = stuck_reg || (t_reg > TIME_W'(TIMEOUT_US)) || (dq == '0)
                      || (dq > QUOT_W'(MAX_DIST));

    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        stuck_next = stuck_reg;
        q_next     = q_reg;
        qm_next    = qm_reg;
        d_next     = d_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    t_next     = echo_time_us;
                    stuck_next = echo_stuck;
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                q_next     = prod[RECIP_SHIFT +: QUOT_W];
                state_next = F_SCL;
            end
            F_SCL: begin
                qm_next    = SCALED_W'(q_reg) * SCALED_W'(US_PER_CM_X100);
                state_next = F_FIX;
            end
            F_FIX: begin
                d_next     = fail ? DIST_W'(MAX_DIST) : dq[DIST_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        t_reg     <= t_next;
        stuck_reg <= stuck_next;
        q_reg     <= q_next;
        qm_reg    <= qm_next;
        d_reg     <= d_next;
    end

    assign s_tready          = (state_reg == F_IDLE);
    assign push_valid        = (state_reg == F_PUSH);
    assign push_data.dist_cm = d_reg;

endmodule
`default_nettype wire

@@ rtl/erta_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module erta_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire erta_pkg::erta_req_t push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output erta_pkg::erta_req_t      pop_data
);
    import erta_pkg::*;

    erta_req_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/erta_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "echo_range_trimmed_average_macros.svh"
module erta_back #(
    parameter int unsigned MAX_DIST    = 400,
    parameter int unsigned RETRY_LIMIT = 5
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire erta_pkg::erta_cfg_t            cfg,
    input  wire logic                           cfg_clear,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire erta_pkg::erta_req_t            pop_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [erta_pkg::DIST_W-1:0]         m_dist_cm,
    output logic [erta_pkg::STATUS_W-1:0]       m_status
);
    import erta_pkg::*;

    localparam int unsigned DIV_W = RUN_W + 1 + SUM_W;
    localparam int unsigned CNT_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [GOOD_W-1:0]   good_count_reg, good_count_next;
    logic [RETRY_W-1:0]  retry_count_reg, retry_count_next;
    logic [DIST_W-1:0]   lowest_reg, lowest_next;
    logic [DIST_W-1:0]   highest_reg, highest_next;
    logic [SUM_W-1:0]    running_sum_reg, running_sum_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [RUN_W-1:0]    divisor_reg, divisor_next;
    logic [DIST_W-1:0]   res_dist_reg, res_dist_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [RUN_W-1:0]    n_eff;
    logic [GOOD_W-1:0]   n_plus2;
    logic [DIST_W:0]     trim;
    logic [SUM_W-1:0]    rest;
    logic [RETRY_W:0]    retry_inc;
    logic [RUN_W:0]      div_shift;
    logic                div_ge;
    logic [RUN_W:0]      div_rem;
    logic [SUM_W-1:0]    quot;

    assign n_eff     = (cfg.run_length == '0) ? RUN_W'(1) : cfg.run_length;
    assign n_plus2   = GOOD_W'(n_eff) + GOOD_W'(2);
    assign trim      = {1'b0, lowest_reg} + {1'b0, highest_reg};
    assign rest      = (running_sum_reg >= SUM_W'(trim)) ? running_sum_reg - SUM_W'(trim)
                                                         : '0;
    assign retry_inc = {1'b0, retry_count_reg} + 1'b1;

    // Restoring division: the remainder stays below the divisor, so its low
    // bits and the next dividend bit make the trial value.
    assign div_shift = {div_reg[SUM_W +: RUN_W], div_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_rem   = div_ge ? div_shift - {1'b0, divisor_reg} : div_shift;
    assign quot      = div_reg[SUM_W-1:0];

    always_comb begin
        state_next       = state_reg;
        dist_next        = dist_reg;
        good_count_next  = good_count_reg;
        retry_count_next = retry_count_reg;
        lowest_next      = lowest_reg;
        highest_next     = highest_reg;
        running_sum_next = running_sum_reg;
        div_next         = div_reg;
        div_cnt_next     = div_cnt_reg;
        divisor_next     = divisor_reg;
        res_dist_next    = res_dist_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_dist_next    = out_dist_reg;
        out_status_next  = out_status_reg;
        pop_ready        = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    dist_next  = pop_data.dist_cm;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (!cfg.avg_en) begin
                    res_dist_next   = dist_reg;
                    res_status_next = STATUS_SINGLE;
                    state_next      = S_OUT;
                end else if (dist_reg == DIST_W'(MAX_DIST)) begin
                    if (retry_inc > (RETRY_W + 1)'(RETRY_LIMIT)) begin
                        good_count_next  = '0;
                        retry_count_next = '0;
                        lowest_next      = LOWEST_RESET;
                        highest_next     = '0;
                        running_sum_next = '0;
                        res_dist_next    = DIST_W'(MAX_DIST);
                        res_status_next  = STATUS_ABORT;
                        state_next       = S_OUT;
                    end else begin
                        retry_count_next = retry_inc[RETRY_W-1:0];
                        state_next       = S_IDLE;
                    end
                end else begin
                    retry_count_next = '0;
                    if (dist_reg < lowest_reg) begin
                        lowest_next = dist_reg;
                    end
                    if (dist_reg > highest_reg) begin
                        highest_next = dist_reg;
                    end
                    running_sum_next = running_sum_reg + SUM_W'(dist_reg);
                    good_count_next  = good_count_reg + 1'b1;
                    state_next       = S_CHK;
                end
            end
            S_CHK: begin
                if (good_count_reg >= n_plus2) begin
                    div_next         = {{(RUN_W + 1){1'b0}}, rest};
                    divisor_next     = n_eff;
                    div_cnt_next     = '0;
                    good_count_next  = '0;
                    retry_count_next = '0;
                    lowest_next      = LOWEST_RESET;
                    highest_next     = '0;
                    running_sum_next = '0;
                    state_next       = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                div_next     = {div_rem, div_reg[SUM_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = S_RES;
                end
            end
            S_RES: begin
                res_dist_next   = (quot > SUM_W'(DIST_SAT)) ? DIST_SAT : quot[DIST_W-1:0];
                res_status_next = STATUS_DONE;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_dist_next   = res_dist_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A register write drops any partial run.
        if (cfg_clear) begin
            good_count_next  = '0;
            retry_count_next = '0;
            lowest_next      = LOWEST_RESET;
            highest_next     = '0;
            running_sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            good_count_reg  <= '0;
            retry_count_reg <= '0;
            lowest_reg      <= LOWEST_RESET;
            highest_reg     <= '0;
            running_sum_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            good_count_reg  <= good_count_next;
            retry_count_reg <= retry_count_next;
            lowest_reg      <= lowest_next;
            highest_reg     <= highest_next;
            running_sum_reg <= running_sum_next;
            out_valid_reg   <= out_valid_next;
        end
        dist_reg       <= dist_next;
        div_reg        <= div_next;
        div_cnt_reg    <= div_cnt_next;
        divisor_reg    <= divisor_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_dist_cm = out_dist_reg;
    assign m_status  = out_status_reg;

    `ERTA_ASSERT(a_retry_in_limit, retry_count_reg <= RETRY_W'(RETRY_LIMIT))
    `ERTA_ASSERT(a_good_in_run, good_count_reg <= n_plus2)
    `ERTA_ASSERT_IMPLY(a_div_only_avg, state_reg == S_DIV, cfg.avg_en)
    `ERTA_ASSERT_IMPLY(a_single_only_off, out_valid_reg && out_status_reg == STATUS_SINGLE,
                       !cfg.avg_en)

endmodule
`default_nettype wire

@@ rtl/echo_range_trimmed_average.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Echo ranging with trimmed-mean averaging.
// Input stream: one request per measured echo. s_tdata carries the echo high
// time in microseconds, s_tuser the flag that the echo line was already high
// before the trigger. Output stream: m_tdata carries the distance in cm,
// m_tuser the status (single reading, average done, average aborted).
// An APB port holds the averaging enable (0x0) and the run length (0x4);
// write them only while the block is idle. A write clears any partial run.
// The front end takes one request at a time: a multiply by a reciprocal, a
// multiply back by the divisor and one correction step, then a push to the
// queue, and it takes no new request until that push is taken. The request
// that completes an average also passes the 18-step serial divider in the
// back end. A two-entry queue between front and back lets new requests
// come in while the back end divides or a result waits.
// Reset clears the run state, the queue and the output; the enable reads 0
// and the run length 1 afterward. When the receiver stalls, the result is
// held in the output register, the back end stops after its next result and
// s_tready stays low once the queue is full and the front end waits to push.
module echo_range_trimmed_average #(
    parameter int unsigned MAX_DIST    = 400,
    parameter int unsigned RETRY_LIMIT = 5,
    parameter int unsigned TIMEOUT_US  = 150000
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [17:0] echo_time_us, [23:18] zero
    input  wire logic        s_tuser,   // [0] echo_stuck
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [9:0] distance_cm, [15:10] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import erta_pkg::*;

    logic             avg_en_reg, avg_en_next;
    logic [RUN_W-1:0] run_length_reg, run_length_next;
    logic             cfg_write;
    erta_cfg_t        cfg;

    logic                push_valid, push_ready;
    erta_req_t           push_data;
    logic                pop_valid, pop_ready;
    erta_req_t           pop_data;
    logic [DIST_W-1:0]   dist_cm;
    logic [STATUS_W-1:0] status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        avg_en_next     = avg_en_reg;
        run_length_next = run_length_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_AVG_EN:  avg_en_next     = pwdata[0];
                REG_RUN_LEN: run_length_next = pwdata[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_en_reg     <= 1'b0;
            run_length_reg <= RUN_W'(1);
        end else begin
            avg_en_reg     <= avg_en_next;
            run_length_reg <= run_length_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_AVG_EN:  prdata = {31'd0, avg_en_reg};
            REG_RUN_LEN: prdata = {{(32 - RUN_W){1'b0}}, run_length_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.avg_en     = avg_en_reg;
    assign cfg.run_length = run_length_reg;

    erta_front #(
        .MAX_DIST   (MAX_DIST),
        .TIMEOUT_US (TIMEOUT_US)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .echo_time_us (s_tdata[TIME_W-1:0]),
        .echo_stuck   (s_tuser),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    erta_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    erta_back #(
        .MAX_DIST    (MAX_DIST),
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cfg_clear (cfg_write),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_dist_cm (dist_cm),
        .m_status  (status)
    );

    assign m_tdata = {{(16 - DIST_W){1'b0}}, dist_cm};
    assign m_tuser = status;

endmodule
`default_nettype wire

@@ bench/range_result_checker.sv @@
`timescale 1ns / 1ps
module range_result_checker
    import erta_pkg::*;
#(
    parameter int unsigned MAX_DIST    = 400,
    parameter int unsigned RETRY_LIMIT = 5,
    parameter int unsigned TIMEOUT_US  = 150000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [17:0] echo_time_us, [23:18] zero
    input  logic        s_tuser,    // [0] echo_stuck
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [9:0] distance_cm, [15:10] zero
    input  logic [1:0]  m_tuser,    // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          averages_seen,
    output int          aborts_seen
);

    localparam int unsigned ECHO_SCALE   = 100;
    localparam int unsigned ECHO_DIVISOR = 5882;
    localparam logic [DIST_W-1:0] DIST_FAIL    = DIST_W'(MAX_DIST);
    localparam logic [2:0]        ADDR_AVG_EN  = {REG_AVG_EN, 2'b00};
    localparam logic [2:0]        ADDR_RUN_LEN = {REG_RUN_LEN, 2'b00};

    typedef struct packed {
        logic [DIST_W-1:0]   distance_cm;
        logic [STATUS_W-1:0] status;
    } range_result_t;

    logic                averaging_on;
    logic [RUN_W-1:0]    run_len;
    logic [GOOD_W-1:0]   good_readings;
    logic [RETRY_W-1:0]  misses_in_row;
    logic [DIST_W-1:0]   run_min;
    logic [DIST_W-1:0]   run_max;
    logic [SUM_W-1:0]    run_total;
    range_result_t       expected_ranges[$];

    function automatic logic [DIST_W-1:0] echo_to_cm(logic [TIME_W-1:0] t, logic stuck);
        int unsigned cm;
        if (stuck || t > TIMEOUT_US) begin
            return DIST_FAIL;
        end
        cm = (int'(t) * ECHO_SCALE) / ECHO_DIVISOR;
        if (cm == 0 || cm > MAX_DIST) begin
            return DIST_FAIL;
        end
        return DIST_W'(cm);
    endfunction

    task automatic clear_run();
        good_readings = '0;
        misses_in_row = '0;
        run_min       = LOWEST_RESET;
        run_max       = '0;
        run_total     = '0;
    endtask

    task automatic project_echo(logic [TIME_W-1:0] t, logic stuck);
        logic [DIST_W-1:0] cm;
        int unsigned       span;
        int unsigned       trim;
        int unsigned       rest;
        int unsigned       mean;
        range_result_t     r;
        cm = echo_to_cm(t, stuck);
        if (!averaging_on) begin
            r.distance_cm = cm;
            r.status      = STATUS_SINGLE;
            expected_ranges.push_back(r);
        end else if (cm == DIST_FAIL) begin
            // Failures only count against the slot; the one past the limit aborts.
            if (int'(misses_in_row) + 1 > RETRY_LIMIT) begin
                clear_run();
                r.distance_cm = DIST_FAIL;
                r.status      = STATUS_ABORT;
                expected_ranges.push_back(r);
            end else begin
                misses_in_row = misses_in_row + 1'b1;
            end
        end else begin
            misses_in_row = '0;
            if (cm < run_min) begin
                run_min = cm;
            end
            if (cm > run_max) begin
                run_max = cm;
            end
            run_total     = run_total + SUM_W'(cm);
            good_readings = good_readings + 1'b1;
            span = (run_len == 0) ? 1 : int'(run_len);
            if (good_readings >= span + 2) begin
                trim = int'(run_min) + int'(run_max);
                rest = (run_total >= trim) ? int'(run_total) - trim : 0;
                mean = rest / span;
                if (mean > DIST_SAT) begin
                    mean = DIST_SAT;
                end
                clear_run();
                r.distance_cm = DIST_W'(mean);
                r.status      = STATUS_DONE;
                expected_ranges.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        range_result_t want;
        if (!aresetn) begin
            averaging_on = 1'b0;
            run_len      = RUN_W'(1);
            clear_run();
            expected_ranges.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_AVG_EN) begin
                    averaging_on = pwdata[0];
                    clear_run();
                end else if (paddr == ADDR_RUN_LEN) begin
                    run_len = pwdata[RUN_W-1:0];
                    clear_run();
                end
            end
            // Retire the outgoing result before predicting the new request.
            if (m_tvalid && m_tready) begin
                if (expected_ranges.size() == 0) begin
                    $error("unexpected result: distance_cm %0d, status %0d",
                           m_tdata[DIST_W-1:0], m_tuser);
                    mismatches++;
                end else begin
                    want = expected_ranges.pop_front();
                    results_seen++;
                    if (want.status == STATUS_DONE) begin
                        averages_seen++;
                    end
                    if (want.status == STATUS_ABORT) begin
                        aborts_seen++;
                    end
                    if (m_tdata[DIST_W-1:0] !== want.distance_cm) begin
                        $error("distance_cm: expected %0d, actual %0d",
                               want.distance_cm, m_tdata[DIST_W-1:0]);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                project_echo(s_tdata[TIME_W-1:0], s_tuser);
            end
        end
        pending = expected_ranges.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import erta_pkg::*;

    localparam int unsigned MAX_DIST      = 400;
    localparam int unsigned RETRY_LIMIT   = 5;
    localparam int unsigned TIMEOUT_US    = 150000;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 64;
    localparam logic [2:0]  ADDR_AVG_EN   = {REG_AVG_EN, 2'b00};
    localparam logic [2:0]  ADDR_RUN_LEN  = {REG_RUN_LEN, 2'b00};
    // Echo times that give distances from 1 cm up to one below the maximum.
    localparam int unsigned GOOD_TIME_MIN = 59;
    localparam int unsigned GOOD_TIME_MAX = 23527;
    localparam int unsigned TIME_AT_MAX   = 23528;
    localparam int unsigned TIME_ALL_ONES = 262143;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // [17:0] echo_time_us, [23:18] zero
    logic        s_tuser  = 1'b0;  // [0] echo_stuck
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;  // [9:0] distance_cm, [15:10] zero
    logic [1:0]  m_tuser;  // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_seen;
    int averages_seen;
    int aborts_seen;
    int echoes_sent    = 0;
    int register_writes = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;

    echo_range_trimmed_average #(
        .MAX_DIST   (MAX_DIST),
        .RETRY_LIMIT(RETRY_LIMIT),
        .TIMEOUT_US (TIMEOUT_US)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    range_result_checker #(
        .MAX_DIST   (MAX_DIST),
        .RETRY_LIMIT(RETRY_LIMIT),
        .TIMEOUT_US (TIMEOUT_US)
    ) range_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .averages_seen(averages_seen),
        .aborts_seen  (aborts_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_echo(logic [TIME_W-1:0] t, logic stuck);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, t};
        s_tuser  <= stuck;
        do @(posedge aclk); while (!s_tready);
        echoes_sent++;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        register_writes++;
    endtask

    // Hold off new requests until every result is out and the block has gone quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(logic averaging, logic [RUN_W-1:0] run_len);
        settle();
        apb_write(ADDR_AVG_EN, {31'd0, averaging});
        apb_write(ADDR_RUN_LEN, {24'd0, run_len});
    endtask

    function automatic logic [TIME_W-1:0] good_time();
        return TIME_W'($urandom_range(GOOD_TIME_MIN, GOOD_TIME_MAX));
    endfunction

    function automatic logic [TIME_W-1:0] boundary_time();
        case ($urandom_range(0, 9))
            0: return TIME_W'(0);
            1: return TIME_W'(1);
            2: return TIME_W'(GOOD_TIME_MIN - 1);
            3: return TIME_W'(GOOD_TIME_MIN);
            4: return TIME_W'(GOOD_TIME_MAX);
            5: return TIME_W'(TIME_AT_MAX);
            6: return TIME_W'(TIME_AT_MAX + 1);
            7: return TIME_W'(TIMEOUT_US);
            8: return TIME_W'(TIMEOUT_US + 1);
            default: return TIME_W'(TIME_ALL_ONES);
        endcase
    endfunction

    task automatic send_failing_echo();
        case ($urandom_range(0, 3))
            0: send_echo(TIME_W'($urandom_range(0, TIME_ALL_ONES)), 1'b1);
            1: send_echo(TIME_W'(0), 1'b0);
            2: send_echo(TIME_W'($urandom_range(TIMEOUT_US + 1, TIME_ALL_ONES)), 1'b0);
            default: send_echo(TIME_W'($urandom_range(1, GOOD_TIME_MIN - 1)), 1'b0);
        endcase
    endtask

    // Clean traffic keeps failure bursts short enough that long runs can finish.
    task automatic send_mixed_echo(bit clean);
        int pick;
        pick = $urandom_range(0, 99);
        if (clean) begin
            if (pick < 90) begin
                send_echo(good_time(), 1'b0);
            end else begin
                repeat ($urandom_range(1, RETRY_LIMIT)) send_failing_echo();
            end
        end else if (pick < 70) begin
            send_echo(good_time(), 1'b0);
        end else if (pick < 80) begin
            send_echo(boundary_time(), 1'b0);
        end else if (pick < 94) begin
            send_echo(TIME_W'($urandom_range(0, TIME_ALL_ONES)), 1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(3, RETRY_LIMIT + 3)) send_failing_echo();
        end
    endtask

    task automatic run_phase(int count, bit clean);
        int target;
        target = echoes_sent + count;
        while (echoes_sent < target) send_mixed_echo(clean);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Single readings across the conversion and failure boundaries.
        send_echo(TIME_W'(0), 1'b0);
        send_echo(TIME_W'(1), 1'b0);
        send_echo(TIME_W'(GOOD_TIME_MIN - 1), 1'b0);
        send_echo(TIME_W'(GOOD_TIME_MIN), 1'b0);
        send_echo(TIME_W'(TIME_AT_MAX), 1'b0);
        send_echo(TIME_W'(TIME_AT_MAX + 1), 1'b0);
        send_echo(TIME_W'(23587), 1'b0);
        send_echo(TIME_W'(TIMEOUT_US), 1'b0);
        send_echo(TIME_W'(TIMEOUT_US + 1), 1'b0);
        send_echo(TIME_W'(TIME_ALL_ONES), 1'b0);
        send_echo(TIME_W'(5000), 1'b1);
        send_echo(TIME_W'(18'h15555), 1'b0);
        send_echo(TIME_W'(18'h2AAAA), 1'b0);

        // Averaging over three readings; a reading at the maximum is a miss.
        settle();
        apb_write(ADDR_AVG_EN, 32'd1);
        send_echo(TIME_W'(1000), 1'b0);
        send_echo(TIME_W'(TIME_AT_MAX), 1'b0);
        send_echo(TIME_W'(2000), 1'b0);
        send_echo(TIME_W'(3000), 1'b0);

        // Six misses in a row abort the run.
        send_echo(TIME_W'(0), 1'b0);
        send_echo(TIME_W'(TIMEOUT_US + 1), 1'b0);
        send_echo(TIME_W'(100), 1'b1);
        send_echo(TIME_W'(TIME_AT_MAX), 1'b0);
        send_echo(TIME_W'(1), 1'b0);
        send_echo(TIME_W'(TIME_ALL_ONES), 1'b0);

        // A register write drops the partial run; a zero run length acts as one.
        send_echo(TIME_W'(5000), 1'b0);
        settle();
        apb_write(ADDR_RUN_LEN, 32'd0);
        send_echo(TIME_W'(GOOD_TIME_MIN), 1'b0);
        send_echo(TIME_W'(GOOD_TIME_MAX), 1'b0);
        send_echo(TIME_W'(12000), 1'b0);

        set_mode(1'b0, RUN_W'(1));
        run_phase(125, 1'b0);
        settle();
        run_phase(125, 1'b0);

        set_mode(1'b1, RUN_W'(1));
        run_phase(250, 1'b0);

        set_mode(1'b1, RUN_W'($urandom_range(2, 12)));
        run_phase(250, 1'b0);

        calm = 1'b1;
        set_mode(1'b1, RUN_W'(255));
        run_phase(300, 1'b1);
        calm = 1'b0;

        set_mode(1'b1, RUN_W'(0));
        run_phase(200, 1'b0);

        set_mode(1'b0, RUN_W'(255));
        run_phase(150, 1'b0);

        set_mode(1'b1, RUN_W'($urandom_range(2, 40)));
        run_phase(250, 1'b1);

        settle();

        $display("Sent %0d echoes through %0d register writes, single and averaging modes.",
                 echoes_sent, register_writes);
        $display("Checked %0d results: %0d averages, %0d aborted runs.",
                 results_seen, averages_seen, aborts_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/erta_pkg.sv
rtl/erta_front.sv
rtl/erta_queue.sv
rtl/erta_back.sv
rtl/echo_range_trimmed_average.sv
bench/range_result_checker.sv
bench/testbench.sv
